[hw/rtl/wpbdl_pkg.sv]
// ----------------------------------------------------------------------------
// World point bilinear distance lookup package
// Shared opcodes, register indexes, sequencer states and field widths.
// ----------------------------------------------------------------------------
package wpbdl_pkg;

   // Opcodes of a request.
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_QUERY = 2'd1,
      OP_MARK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_YAW_COS    = 3'd2,
      CSR_YAW_SIN    = 3'd3,
      CSR_CELLS_PM   = 3'd4,
      CSR_PAD_WIDTH  = 3'd5,
      CSR_PAD_HEIGHT = 3'd6,
      CSR_PAD_CELLS  = 3'd7
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_SCALE,
      ST_GRID,
      ST_CHECK,
      ST_READ,
      ST_BLEND,
      ST_WEIGHT,
      ST_SUM,
      ST_FINISH
   } state_type;

   localparam int CSR_DATA_W = 32;
   localparam int DIST_W     = 16;
   localparam int POINT_W    = 32;

   localparam logic [16:0] ONE_Q16       = 17'h10000;
   localparam logic [49:0] HALF_CELL_Q16 = 50'd32768;

endpackage

[hw/rtl/wpbdl_if.sv]
// ----------------------------------------------------------------------------
// World point bilinear distance lookup channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface wpbdl_req_if;
   import wpbdl_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          opcode;
   logic [7:0]          entry_column;
   logic [7:0]          entry_row;
   logic [DIST_W-1:0]   entry_distance;
   logic signed [31:0]  point_x;
   logic signed [31:0]  point_y;
   logic [DIST_W-1:0]   fallback_distance;

   modport source (output valid, opcode, entry_column, entry_row, entry_distance,
                   point_x, point_y, fallback_distance, input ready);
   modport sink   (input valid, opcode, entry_column, entry_row, entry_distance,
                   point_x, point_y, fallback_distance, output ready);
endinterface

interface wpbdl_rsp_if;
   import wpbdl_pkg::*;

   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance_out;
   logic              off_map;

   modport source (output valid, distance_out, off_map, input ready);
   modport sink   (input valid, distance_out, off_map, output ready);
endinterface

[hw/rtl/wpbdl_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wpbdl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/world_point_bilinear_distance_lookup_unit.sv]
// ----------------------------------------------------------------------------
// World point bilinear distance lookup unit
// Maps a world point into a padded distance grid and interpolates it.
// ----------------------------------------------------------------------------
// Channel    Direction  Handshake      Contents
// req_port   in         valid/ready    opcode, entry fields, point, fallback
// rsp_port   out        valid/ready    distance_out, off_map
// csr_*      in         write enable   register index and data
//
// Write, mark and clear requests go from idle straight to finish. A query walks
// rotate, scale, grid and check, reads the four neighbours through the single
// read port of the table RAM, then blends, weights and sums, or skips to finish
// when it falls off the map or the table is not ready. Only idle takes requests.
// Reset is synchronous and clears control state; table contents are undefined
// until written. A stalled response holds the unit in its last state.
// ----------------------------------------------------------------------------
module world_point_bilinear_distance_lookup_unit #(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS    = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   wpbdl_req_if.sink                     req_port,
   wpbdl_rsp_if.source                   rsp_port,
   input  logic                          csr_write_enable,
   input  logic [2:0]                    csr_index,
   input  logic [wpbdl_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import wpbdl_pkg::*;

   localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int AW = $clog2(DEPTH);
   localparam logic [12:0] COLS13 = 13'(MAX_COLUMNS);
   localparam logic [12:0] ROWS13 = 13'(MAX_ROWS);

   // Configuration registers.
   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic signed [15:0] yaw_cos_ff, yaw_sin_ff;
   logic [23:0]        cells_pm_ff;
   logic [8:0]         pad_width_ff, pad_height_ff;
   logic [6:0]         pad_cells_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         yaw_cos_ff    <= 16'sd16384;
         yaw_sin_ff    <= '0;
         cells_pm_ff   <= 24'd81920;
         pad_width_ff  <= 9'd256;
         pad_height_ff <= 9'd256;
         pad_cells_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:   origin_x_ff   <= csr_write_data;
            CSR_ORIGIN_Y:   origin_y_ff   <= csr_write_data;
            CSR_YAW_COS:    yaw_cos_ff    <= csr_write_data[15:0];
            CSR_YAW_SIN:    yaw_sin_ff    <= csr_write_data[15:0];
            CSR_CELLS_PM:   cells_pm_ff   <= csr_write_data[23:0];
            CSR_PAD_WIDTH:  pad_width_ff  <= csr_write_data[8:0];
            CSR_PAD_HEIGHT: pad_height_ff <= csr_write_data[8:0];
            CSR_PAD_CELLS:  pad_cells_ff  <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   // Effective grid size, clamped to the table dimensions.
   logic [12:0] width_eff, height_eff;
   assign width_eff  = ({4'd0, pad_width_ff} > COLS13) ? COLS13 : {4'd0, pad_width_ff};
   assign height_eff = ({4'd0, pad_height_ff} > ROWS13) ? ROWS13 : {4'd0, pad_height_ff};

   state_type state_ff, state_in;
   logic [2:0] read_cnt_ff;
   logic       table_ready_ff;
   logic       accept;
   logic       rsp_free;
   logic       off_decision;

   assign accept   = req_port.valid && req_port.ready;
   assign rsp_free = !rsp_port.valid || rsp_port.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (op_type'(req_port.opcode) == OP_QUERY) ? ST_ROTATE : ST_FINISH;
            end
         end
         ST_ROTATE: state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_GRID;
         ST_GRID:   state_in = ST_CHECK;
         ST_CHECK:  state_in = off_decision ? ST_FINISH : ST_READ;
         ST_READ: begin
            if (read_cnt_ff == 3'd4) begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND:  state_in = ST_WEIGHT;
         ST_WEIGHT: state_in = ST_SUM;
         ST_SUM:    state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Point registers along the datapath.
   logic signed [48:0] p_cdx_ff, p_sdy_ff, p_cdy_ff, p_sdx_ff;
   logic signed [35:0] lx_ff, ly_ff;
   logic signed [48:0] mx_hi_ff, mx_lo_ff, my_hi_ff, my_lo_ff;
   logic signed [49:0] gx_ff, gy_ff;
   logic [CW-1:0]      x0_ff, x1_ff;
   logic [RW-1:0]      y0_ff, y1_ff;
   logic [15:0]        fx_ff, fy_ff;
   logic [DIST_W-1:0]  nb_ff [4];
   logic [32:0]        d0_ff, d1_ff;
   logic [49:0]        t0_ff, t1_ff;
   logic [DIST_W-1:0]  fallback_ff;
   logic [DIST_W-1:0]  res_dist_ff;
   logic               res_off_ff;

   // Rotation operands from the request.
   logic signed [32:0] dx, dy;
   assign dx = $signed({req_port.point_x[31], req_port.point_x})
             - $signed({origin_x_ff[31], origin_x_ff});
   assign dy = $signed({req_port.point_y[31], req_port.point_y})
             - $signed({origin_y_ff[31], origin_y_ff});

   // Floor shift of the rotated sums.
   logic signed [49:0] sum_x, sum_y;
   assign sum_x = 50'(p_cdx_ff) + 50'(p_sdy_ff);
   assign sum_y = 50'(p_cdy_ff) - 50'(p_sdx_ff);

   // Scale factor split into two 12-bit halves.
   logic signed [12:0] cpm_lo, cpm_hi;
   assign cpm_lo = $signed({1'b0, cells_pm_ff[11:0]});
   assign cpm_hi = $signed({1'b0, cells_pm_ff[23:12]});

   // Grid coordinates in Q.16 with half-cell offset and padding.
   logic signed [49:0] pad_q16;
   logic signed [49:0] gx_in, gy_in;
   assign pad_q16 = $signed({27'd0, pad_cells_ff, 16'd0});
   assign gx_in = 50'(mx_hi_ff) + 50'(mx_lo_ff >>> 12) - $signed(HALF_CELL_Q16) + pad_q16;
   assign gy_in = 50'(my_hi_ff) + 50'(my_lo_ff >>> 12) - $signed(HALF_CELL_Q16) + pad_q16;

   // Range check against the padded grid.
   logic signed [49:0] lim_x, lim_y;
   logic [12:0] x0_wide, y0_wide, x0_next, y0_next;
   assign lim_x = $signed({21'd0, width_eff - 13'd1, 16'd0});
   assign lim_y = $signed({21'd0, height_eff - 13'd1, 16'd0});
   assign off_decision = !table_ready_ff || width_eff == 13'd0 || height_eff == 13'd0
                       || gx_ff[49] || gy_ff[49] || gx_ff > lim_x || gy_ff > lim_y;
   assign x0_wide = 13'(gx_ff[28:16]);
   assign y0_wide = 13'(gy_ff[28:16]);
   assign x0_next = (x0_wide + 13'd1 < width_eff) ? x0_wide + 13'd1 : width_eff - 13'd1;
   assign y0_next = (y0_wide + 13'd1 < height_eff) ? y0_wide + 13'd1 : height_eff - 13'd1;

   // Blend weights.
   logic [16:0] cfx, cfy;
   assign cfx = ONE_Q16 - {1'b0, fx_ff};
   assign cfy = ONE_Q16 - {1'b0, fy_ff};

   logic [50:0] blend_sum;
   assign blend_sum = {1'b0, t0_ff} + {1'b0, t1_ff};

   // Table RAM ports.
   logic            ram_wr_en, ram_rd_en;
   logic [AW-1:0]   ram_wr_addr, ram_rd_addr;
   logic [DIST_W-1:0] ram_rd_data;
   logic [CW-1:0]   rd_col;
   logic [RW-1:0]   rd_row;
   logic            entry_in_range;

   assign entry_in_range = ({5'd0, req_port.entry_column} < COLS13)
                        && ({5'd0, req_port.entry_row} < ROWS13);

   // Control outputs of the sequencer.
   always_comb begin
      req_port.ready = (state_ff == ST_IDLE);
      ram_wr_en      = accept && op_type'(req_port.opcode) == OP_WRITE && entry_in_range;
      ram_rd_en      = (state_ff == ST_READ) && read_cnt_ff < 3'd4;
      rd_col         = read_cnt_ff[0] ? x1_ff : x0_ff;
      rd_row         = read_cnt_ff[1] ? y1_ff : y0_ff;
   end

   assign ram_wr_addr = AW'(AW'(req_port.entry_row) * AW'(MAX_COLUMNS))
                      + AW'(req_port.entry_column);
   assign ram_rd_addr = AW'(AW'(rd_row) * AW'(MAX_COLUMNS)) + AW'(rd_col);

   wpbdl_ram #(
      .WIDTH (DIST_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_port.entry_distance),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         read_cnt_ff    <= '0;
         table_ready_ff <= 1'b0;
         rsp_port.valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && op_type'(req_port.opcode) == OP_MARK) begin
            table_ready_ff <= 1'b1;
         end else if (accept && op_type'(req_port.opcode) == OP_CLEAR) begin
            table_ready_ff <= 1'b0;
         end
         if (state_ff == ST_READ) begin
            read_cnt_ff <= read_cnt_ff + 3'd1;
         end else begin
            read_cnt_ff <= '0;
         end
         if (state_ff == ST_FINISH && rsp_free) begin
            rsp_port.valid <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_port.valid <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         p_cdx_ff    <= 49'(yaw_cos_ff * dx);
         p_sdy_ff    <= 49'(yaw_sin_ff * dy);
         p_cdy_ff    <= 49'(yaw_cos_ff * dy);
         p_sdx_ff    <= 49'(yaw_sin_ff * dx);
         fallback_ff <= req_port.fallback_distance;
         res_dist_ff <= '0;
         res_off_ff  <= 1'b0;
      end
      if (state_ff == ST_ROTATE) begin
         lx_ff <= sum_x[49:14];
         ly_ff <= sum_y[49:14];
      end
      if (state_ff == ST_SCALE) begin
         mx_hi_ff <= 49'(lx_ff * cpm_hi);
         mx_lo_ff <= 49'(lx_ff * cpm_lo);
         my_hi_ff <= 49'(ly_ff * cpm_hi);
         my_lo_ff <= 49'(ly_ff * cpm_lo);
      end
      if (state_ff == ST_GRID) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      if (state_ff == ST_CHECK) begin
         x0_ff <= CW'(x0_wide);
         y0_ff <= RW'(y0_wide);
         x1_ff <= CW'(x0_next);
         y1_ff <= RW'(y0_next);
         fx_ff <= gx_ff[15:0];
         fy_ff <= gy_ff[15:0];
         if (off_decision) begin
            res_dist_ff <= fallback_ff;
            res_off_ff  <= 1'b1;
         end
      end
      // Neighbour data arrives in the cycle after its address.
      if (state_ff == ST_READ && read_cnt_ff != 3'd0) begin
         nb_ff[2'(read_cnt_ff - 3'd1)] <= ram_rd_data;
      end
      if (state_ff == ST_BLEND) begin
         d0_ff <= 33'(cfx * nb_ff[0]) + 33'({1'b0, fx_ff} * nb_ff[1]);
         d1_ff <= 33'(cfx * nb_ff[2]) + 33'({1'b0, fx_ff} * nb_ff[3]);
      end
      if (state_ff == ST_WEIGHT) begin
         t0_ff <= 50'(cfy * d0_ff);
         t1_ff <= 50'({1'b0, fy_ff} * d1_ff);
      end
      if (state_ff == ST_SUM) begin
         res_dist_ff <= blend_sum[47:32];
         res_off_ff  <= 1'b0;
      end
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_port.distance_out <= res_dist_ff;
         rsp_port.off_map      <= res_off_ff;
      end
   end
endmodule

[verif/wpbdl_lookup_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Distance lookup checker
// Watches the request and response channels, predicts each response from its
// own copy of the registers and the table, and compares every field in order.
// ----------------------------------------------------------------------------
module wpbdl_lookup_checker
   import wpbdl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   wpbdl_req_if        req_mon,
   wpbdl_rsp_if        rsp_mon,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data,
   output int          mismatch_count,
   output int          pending_count
);

   typedef struct packed {
      logic [15:0] distance;
      logic        off_map;
   } distance_result_type;

   // Local copy of the block state.
   logic [15:0] grid_copy [0:65535];
   logic        grid_ready;
   logic signed [31:0] org_x, org_y;
   logic signed [15:0] cos_q14, sin_q14;
   logic [23:0] scale_q12;
   logic [8:0]  width_cells, height_cells;
   logic [6:0]  border_cells;

   distance_result_type expected_distances [$];

   task automatic report_mismatch(input string what);
      $display("%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic longint floor_div(input longint a, input int k);
      return a >>> k;
   endfunction

   // Transform a point into the padded grid and interpolate.
   function automatic distance_result_type lookup_distance(input logic signed [31:0] px,
         input logic signed [31:0] py, input logic [15:0] fallback);
      distance_result_type r;
      longint dx, dy, lx, ly, gx, gy, w, h, x0, y0, x1, y1;
      longint unsigned fx, fy, d0, d1, acc;
      r.distance = fallback;
      r.off_map  = 1'b1;
      w = (width_cells > 9'd256) ? 256 : longint'(width_cells);
      h = (height_cells > 9'd256) ? 256 : longint'(height_cells);
      if (!grid_ready || w == 0 || h == 0) return r;
      dx = longint'(px) - longint'(org_x);
      dy = longint'(py) - longint'(org_y);
      lx = floor_div(longint'(cos_q14) * dx + longint'(sin_q14) * dy, 14);
      ly = floor_div(longint'(cos_q14) * dy - longint'(sin_q14) * dx, 14);
      gx = floor_div(lx * longint'(scale_q12), 12) - 32768 + longint'(border_cells) * 65536;
      gy = floor_div(ly * longint'(scale_q12), 12) - 32768 + longint'(border_cells) * 65536;
      if (gx < 0 || gy < 0 || gx > (w - 1) * 65536 || gy > (h - 1) * 65536) return r;
      x0 = gx >>> 16;
      y0 = gy >>> 16;
      fx = gx & 16'hFFFF;
      fy = gy & 16'hFFFF;
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
      d0 = (65536 - fx) * grid_copy[y0 * 256 + x0] + fx * grid_copy[y0 * 256 + x1];
      d1 = (65536 - fx) * grid_copy[y1 * 256 + x0] + fx * grid_copy[y1 * 256 + x1];
      acc = (65536 - fy) * d0 + fy * d1;
      r.distance = acc[47:32];
      r.off_map  = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      distance_result_type exp_r;
      if (reset) begin
         grid_ready     <= 1'b0;
         org_x          <= '0;
         org_y          <= '0;
         cos_q14        <= 16'sd16384;
         sin_q14        <= '0;
         scale_q12      <= 24'd81920;
         width_cells    <= 9'd256;
         height_cells   <= 9'd256;
         border_cells   <= '0;
         mismatch_count <= 0;
         pending_count  <= 0;
         expected_distances.delete();
      end else begin
         // Register writes.
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_ORIGIN_X:   org_x        <= csr_write_data;
               CSR_ORIGIN_Y:   org_y        <= csr_write_data;
               CSR_YAW_COS:    cos_q14      <= csr_write_data[15:0];
               CSR_YAW_SIN:    sin_q14      <= csr_write_data[15:0];
               CSR_CELLS_PM:   scale_q12    <= csr_write_data[23:0];
               CSR_PAD_WIDTH:  width_cells  <= csr_write_data[8:0];
               CSR_PAD_HEIGHT: height_cells <= csr_write_data[8:0];
               CSR_PAD_CELLS:  border_cells <= csr_write_data[6:0];
               default: ;
            endcase
         end
         // Compare responses against the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_distances.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               exp_r = expected_distances.pop_front();
               if (rsp_mon.distance_out !== exp_r.distance)
                  report_mismatch($sformatf("distance_out got %h want %h",
                     rsp_mon.distance_out, exp_r.distance));
               if (rsp_mon.off_map !== exp_r.off_map)
                  report_mismatch($sformatf("off_map got %b want %b",
                     rsp_mon.off_map, exp_r.off_map));
            end
         end
         // Predict accepted requests.
         if (req_mon.valid && req_mon.ready) begin
            exp_r = '0;
            case (op_type'(req_mon.opcode))
               OP_WRITE: grid_copy[{req_mon.entry_row, req_mon.entry_column}] =
                  req_mon.entry_distance;
               OP_QUERY: exp_r = lookup_distance(req_mon.point_x, req_mon.point_y,
                  req_mon.fallback_distance);
               OP_MARK:  grid_ready <= 1'b1;
               default:  grid_ready <= 1'b0;
            endcase
            expected_distances.push_back(exp_r);
         end
         // Outstanding predictions for the stimulus side.
         pending_count <= expected_distances.size();
      end
   end

endmodule

[verif/world_point_bilinear_distance_lookup_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Distance lookup unit testbench
// Loads small grids, sweeps register settings and sends directed and random
// queries under random idling and a long response stall.
// ----------------------------------------------------------------------------
module world_point_bilinear_distance_lookup_unit_test;
   import wpbdl_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_write_data = '0;
   int mismatch_count;
   int pending_count;
   int idle_cycles;
   bit steady_phase = 1'b0;
   bit hold_responses = 1'b0;
   bit run_done = 1'b0;

   // Grid size currently loaded; all queries stay inside written entries.
   int grid_w, grid_h;

   wpbdl_req_if req_chan();
   wpbdl_rsp_if rsp_chan();

   world_point_bilinear_distance_lookup_unit dut (
      .clock(clock), .reset(reset), .req_port(req_chan.sink), .rsp_port(rsp_chan.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data));

   wpbdl_lookup_checker checker_inst (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .mismatch_count(mismatch_count),
      .pending_count(pending_count));

   always #5 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.opcode = '0;
      req_chan.entry_column = '0;
      req_chan.entry_row = '0;
      req_chan.entry_distance = '0;
      req_chan.point_x = '0;
      req_chan.point_y = '0;
      req_chan.fallback_distance = '0;
      rsp_chan.ready = 1'b0;
   end

   // Response side: random back-pressure, plus a long hold when asked.
   always @(posedge clock) begin
      if (reset || hold_responses)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= steady_phase || ($urandom_range(99) >= 32);
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
            || hold_responses)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!run_done && idle_cycles > WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Offer one request and hold it until accepted.
   task automatic send_request(input op_type op, input int col, input int row,
         input int entry_dist, input int px, input int py, input int fallback);
      while (!steady_phase && $urandom_range(99) < 32) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.entry_column <= 8'(col);
      req_chan.entry_row <= 8'(row);
      req_chan.entry_distance <= 16'(entry_dist);
      req_chan.point_x <= px;
      req_chan.point_y <= py;
      req_chan.fallback_distance <= 16'(fallback);
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Fill the whole padded grid so no query touches an unwritten entry.
   task automatic load_grid(input int w, input int h, input bit extremes);
      int d;
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++) begin
            d = extremes ? (((r + c) % 2) ? 'hFFFF : 0) : int'($urandom_range(65535));
            send_request(OP_WRITE, c, r, d, $urandom, $urandom, $urandom);
         end
      grid_w = w;
      grid_h = h;
   endtask

   // Random query: mostly landing near the grid under identity-like settings.
   task automatic random_query();
      logic [31:0] px, py;
      if ($urandom_range(3) == 0) begin
         px = $urandom;
         py = $urandom;
      end else begin
         px = $urandom_range(0, (grid_w + 1) * 3277) - 3277;
         py = $urandom_range(0, (grid_h + 1) * 3277) - 3277;
      end
      send_request(OP_QUERY, $urandom, $urandom, $urandom, px, py, $urandom);
   endtask

   task automatic random_request();
      int pick;
      pick = $urandom_range(99);
      if (pick < 80)
         random_query();
      else if (pick < 88)
         send_request(OP_WRITE, $urandom_range(grid_w - 1), $urandom_range(grid_h - 1),
            $urandom, $urandom, $urandom, $urandom);
      else if (pick < 96)
         send_request(OP_MARK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
         send_request(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic set_geometry(input int w, input int h, input int pad,
         input logic [31:0] cpm, input logic [31:0] c, input logic [31:0] s,
         input logic [31:0] ox, input logic [31:0] oy);
      write_csr(CSR_PAD_WIDTH, w);
      write_csr(CSR_PAD_HEIGHT, h);
      write_csr(CSR_PAD_CELLS, pad);
      write_csr(CSR_CELLS_PM, cpm);
      write_csr(CSR_YAW_COS, c);
      write_csr(CSR_YAW_SIN, s);
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: query before ready, small grid, edges and extremes.
      set_geometry(4, 3, 0, 32'd81920, 32'd16384, 32'd0, 32'd0, 32'd0);
      send_request(OP_QUERY, 0, 0, 0, 32'h0, 32'h0, 'hFFFF);
      load_grid(4, 3, 1'b1);
      send_request(OP_QUERY, 'hFF, 'hFF, 'hFFFF, 32'h0, 32'h0, 'h1234);
      send_request(OP_MARK, 'hFF, 'hFF, 'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 'hFFFF);
      send_request(OP_QUERY, 0, 0, 0, 32'h0000_0CCD, 32'h0000_0CCD, 0);
      send_request(OP_QUERY, 0, 0, 0, 32'h0000_2E00, 32'h0000_1B33, 'hAAAA);
      send_request(OP_QUERY, 0, 0, 0, 32'h0000_2E66, 32'h0000_2000, 'h5555);
      send_request(OP_QUERY, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 'hFFFF);
      send_request(OP_QUERY, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 'h0001);
      send_request(OP_QUERY, 0, 0, 0, 32'h0000_1000, 32'h0000_1000, 0);
      send_request(OP_CLEAR, 0, 0, 0, 0, 0, 0);
      send_request(OP_QUERY, 0, 0, 0, 32'h0000_1000, 32'h0000_1000, 'h7777);
      send_request(OP_MARK, 0, 0, 0, 0, 0, 0);
      drain_responses();

      // Zero and oversized grid sizes; extreme register values.
      set_geometry(0, 3, 127, 32'hFFFFFF, 32'h0000_C000, 32'h0000_4000,
         32'h80000000, 32'h7FFFFFFF);
      send_request(OP_QUERY, 0, 0, 0, 32'h0, 32'h0, 'hBEEF);
      drain_responses();
      write_csr(CSR_PAD_WIDTH, 32'd4);
      write_csr(CSR_PAD_HEIGHT, 32'd0);
      send_request(OP_QUERY, 0, 0, 0, 32'h0, 32'h0, 'hBEEF);
      drain_responses();
      set_geometry(4, 3, 0, 32'd1, 32'd16384, 32'd0, 32'd0, 32'd0);
      send_request(OP_QUERY, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 'h4444);
      drain_responses();

      // Phase A: identity rotation, random small grid, steady flow then random idling.
      set_geometry(6, 5, 0, 32'd81920, 32'd16384, 32'd0, 32'd0, 32'd0);
      load_grid(6, 5, 1'b0);
      send_request(OP_MARK, 0, 0, 0, 0, 0, 0);
      steady_phase = 1'b1;
      for (int i = 0; i < 100; i++) random_request();
      steady_phase = 1'b0;
      for (int i = 0; i < 130; i++) random_request();

      // Long response stall while requests keep coming.
      fork
         begin
            hold_responses = 1'b1;
            repeat (300) @(posedge clock);
            hold_responses = 1'b0;
         end
         for (int i = 0; i < 40; i++) random_request();
      join
      drain_responses();

      // Phase B: padding and a rotated, shifted map.
      set_geometry(8, 6, 2, 32'd40960, 32'd11585, 32'h0000_D2BF, 32'hFFFF_8000,
         32'h0000_4000);
      load_grid(8, 6, 1'b0);
      send_request(OP_MARK, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 80; i++) random_request();
      drain_responses();

      // Phase C: oversized width clamps; reverse yaw with scale 0x00FFFF.
      set_geometry(300, 2, 1, 32'h00FFFF, 32'h0000_C000, 32'd0, 32'd0, 32'd0);
      load_grid(256, 2, 1'b0);
      send_request(OP_MARK, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 80; i++) random_request();
      drain_responses();

      run_done = 1'b1;
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
hw/rtl/wpbdl_pkg.sv
hw/rtl/wpbdl_if.sv
hw/rtl/wpbdl_ram.sv
hw/rtl/world_point_bilinear_distance_lookup_unit.sv
verif/wpbdl_lookup_checker.sv
verif/world_point_bilinear_distance_lookup_unit_test.sv
